// ===== hw/rtl/ffa_pkg.sv =====
package ffa_pkg;

	localparam int unsigned MAX_REGIONS_DEF = 256;
	localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
	localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] req_addr;
		logic [31:0] req_size;
	} ffa_req_t;

	typedef struct packed {
		logic [31:0] alloc_addr;
		logic        success;
		logic [31:0] free_total;
		logic [8:0]  region_count;
		logic [8:0]  peak_regions;
		logic [31:0] lost_frees;
		logic [31:0] lost_bytes;
	} ffa_rsp_t;

	// one free-table entry
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} ffa_entry_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_EV   = 8'b0000_0100,
		S_DEC  = 8'b0000_1000,
		S_SHRD = 8'b0001_0000,
		S_SHEV = 8'b0010_0000,
		S_WR   = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} ffa_state_t;

endpackage

// ===== hw/rtl/first_fit_free_list_allocator.sv =====
// channel | dir | handshake            | word
// cfg     | in  | cfg_valid/cfg_ready  | round_to_page bit
// in      | in  | in_valid/in_ready    | ffa_req_t (kind, req_addr, req_size)
// out     | out | out_valid/out_ready  | ffa_rsp_t (one per request)
//
// One request at a time. Each scanned entry is a memory read, then a compare;
// each shifted entry is another read, then a write of the neighbor into place.
// The region table has one read port and one registered write port.
// Reset clears counters and control only; the table needs no clearing since
// only entries below the count are read.
// A finished word waits in the output register; a new word is taken meanwhile.
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data,
	input  logic     in_valid,
	output logic     in_ready,
	input  ffa_req_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ffa_rsp_t out_data
);

	localparam int unsigned AW = $clog2(MAX_REGIONS);
	localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

	ffa_state_t state_q;

	logic          round_q;
	logic [CW-1:0] used_q, peak_q;
	logic [31:0]   total_q, lost_n_q, lost_b_q;

	// current request
	logic          kind_q;
	logic [31:0]   addr_q, size_q;
	logic [CW-1:0] idx_q;        // scan position
	logic [AW-1:0] sh_q;         // shift position
	logic          up_q;         // shift direction: 1 opens a hole
	ffa_entry_t    prev_q, cur_q, new_q;
	logic          prev_ok_q, cur_ok_q;
	logic [31:0]   res_addr_q;
	logic          ok_q;

	// registered write port
	logic          wr_en_q;
	logic [AW-1:0] wr_addr_q;
	ffa_entry_t    wr_data_q;

	logic [AW-1:0] rd_addr;
	ffa_entry_t    rd_data;

	logic          out_valid_q;
	ffa_rsp_t      out_q;

	logic [31:0]   req_size_r;
	logic [31:0]   end_w;

	ffa_mem #(.DEPTH(MAX_REGIONS)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en_q),
		.wr_addr (wr_addr_q),
		.wr_data (wr_data_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign req_size_r = round_q ? ((in_data.req_size + PAGE_ADD) & PAGE_MASK)
	                            : in_data.req_size;
	assign end_w = addr_q + size_q;

	// scan reads at idx, shifts read the neighbor that moves into sh
	always_comb begin
		if (state_q == S_SHRD) begin
			rd_addr = up_q ? (sh_q - 1'b1) : (sh_q + 1'b1);
		end else begin
			rd_addr = idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			round_q     <= 1'b0;
			used_q      <= '0;
			peak_q      <= '0;
			total_q     <= '0;
			lost_n_q    <= '0;
			lost_b_q    <= '0;
			wr_en_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_en_q <= 1'b0;
			if (cfg_valid) begin
				round_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q     <= in_data.kind;
						addr_q     <= in_data.req_addr;
						size_q     <= req_size_r;
						idx_q      <= '0;
						prev_ok_q  <= 1'b0;
						cur_ok_q   <= 1'b0;
						res_addr_q <= '0;
						ok_q       <= 1'b0;
						state_q    <= (used_q == '0) ? S_DEC : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (kind_q == KIND_ALLOC) begin
						if (rd_data.length >= size_q) begin
							res_addr_q <= rd_data.start;
							ok_q       <= 1'b1;
							total_q    <= total_q - size_q;
							if (rd_data.length == size_q) begin
								// region emptied: close the gap
								used_q  <= used_q - 1'b1;
								sh_q    <= idx_q[AW-1:0];
								up_q    <= 1'b0;
								state_q <= (idx_q + 1'b1 < used_q) ? S_SHRD : S_DONE;
							end else begin
								wr_en_q          <= 1'b1;
								wr_addr_q        <= idx_q[AW-1:0];
								wr_data_q.start  <= rd_data.start + size_q;
								wr_data_q.length <= rd_data.length - size_q;
								state_q          <= S_DONE;
							end
						end else if (idx_q + 1'b1 == used_q) begin
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						if (rd_data.start > addr_q) begin
							cur_q    <= rd_data;
							cur_ok_q <= 1'b1;
							state_q  <= S_DEC;
						end else begin
							prev_q    <= rd_data;
							prev_ok_q <= 1'b1;
							idx_q     <= idx_q + 1'b1;
							state_q   <= (idx_q + 1'b1 == used_q) ? S_DEC : S_RD;
						end
					end
				end
				S_DEC: begin
					// idx is the first entry above the freed address
					if (kind_q == KIND_ALLOC) begin
						state_q <= S_DONE;
					end else if (prev_ok_q && (prev_q.start + prev_q.length == addr_q)) begin
						ok_q            <= 1'b1;
						total_q         <= total_q + size_q;
						wr_en_q         <= 1'b1;
						wr_addr_q       <= AW'(idx_q - 1'b1);
						wr_data_q.start <= prev_q.start;
						if (cur_ok_q && end_w == cur_q.start) begin
							wr_data_q.length <= prev_q.length + size_q + cur_q.length;
							used_q  <= used_q - 1'b1;
							sh_q    <= idx_q[AW-1:0];
							up_q    <= 1'b0;
							state_q <= (idx_q + 1'b1 < used_q) ? S_SHRD : S_DONE;
						end else begin
							wr_data_q.length <= prev_q.length + size_q;
							state_q          <= S_DONE;
						end
					end else if (cur_ok_q && end_w == cur_q.start) begin
						ok_q             <= 1'b1;
						total_q          <= total_q + size_q;
						wr_en_q          <= 1'b1;
						wr_addr_q        <= idx_q[AW-1:0];
						wr_data_q.start  <= addr_q;
						wr_data_q.length <= cur_q.length + size_q;
						state_q          <= S_DONE;
					end else if (used_q < MAX_CNT) begin
						ok_q         <= 1'b1;
						total_q      <= total_q + size_q;
						new_q.start  <= addr_q;
						new_q.length <= size_q;
						sh_q         <= used_q[AW-1:0];
						up_q         <= 1'b1;
						state_q      <= (used_q > idx_q) ? S_SHRD : S_WR;
					end else begin
						lost_n_q <= lost_n_q + 1'b1;
						lost_b_q <= lost_b_q + size_q;
						state_q  <= S_DONE;
					end
				end
				S_SHRD: begin
					state_q <= S_SHEV;
				end
				S_SHEV: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= sh_q;
					wr_data_q <= rd_data;
					if (up_q) begin
						sh_q    <= sh_q - 1'b1;
						state_q <= (sh_q - 1'b1 == idx_q[AW-1:0]) ? S_WR : S_SHRD;
					end else begin
						sh_q    <= sh_q + 1'b1;
						state_q <= (CW'(sh_q) + 2'd2 < used_q + 1'b1) ? S_SHRD : S_DONE;
					end
				end
				S_WR: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= idx_q[AW-1:0];
					wr_data_q <= new_q;
					used_q    <= used_q + 1'b1;
					if (peak_q < used_q + 1'b1) begin
						peak_q <= used_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q        <= 1'b1;
						out_q.alloc_addr   <= res_addr_q;
						out_q.success      <= ok_q;
						out_q.free_total   <= total_q;
						out_q.region_count <= 9'(used_q);
						out_q.peak_regions <= 9'(peak_q);
						out_q.lost_frees   <= lost_n_q;
						out_q.lost_bytes   <= lost_b_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_WR) begin
				state_q <= S_DONE;
			end
		end
	end

	// table count never passes its depth, peak never trails the count
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= MAX_CNT) else $error("region count above table depth");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q) else $error("peak below region count");

	// a word is only loaded from the done state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word without finished request");

	// a drop only happens with a full table
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(lost_n_q != $past(lost_n_q)) |-> $past(used_q == MAX_CNT))
		else $error("free dropped with room left");

endmodule

// ===== hw/rtl/ffa_mem.sv =====
module ffa_mem
	import ffa_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_REGIONS_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ffa_entry_t    wr_data,
	input  logic [AW-1:0] rd_addr,
	output ffa_entry_t    rd_data
);

	ffa_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import ffa_pkg::*;

	localparam int TABLE_DEPTH = MAX_REGIONS_DEF;
	localparam int CYCLE_LIMIT = 8000000;

	logic     clk;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	logic     cfg_data;
	logic     in_valid;
	logic     in_ready;
	ffa_req_t in_data;
	logic     out_valid;
	logic     out_ready;
	ffa_rsp_t out_data;

	first_fit_free_list_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// shadow copy of the free table and counters
	logic [31:0] sh_start [TABLE_DEPTH];
	logic [31:0] sh_len   [TABLE_DEPTH];
	int          sh_used = 0;
	int          sh_peak = 0;
	logic [31:0] sh_lost_cnt = '0;
	logic [31:0] sh_lost_bytes = '0;
	logic        sh_round = 1'b0;

	ffa_req_t pending_reqs[$];
	ffa_rsp_t expected_rsps[$];
	int       error_count = 0;
	int       cycle_count = 0;
	bit       quiet_tail;   // no idling near the end

	function automatic void drop_entry(int idx);
		sh_used--;
		for (int k = idx; k < sh_used; k++) begin
			sh_start[k] = sh_start[k + 1];
			sh_len[k]   = sh_len[k + 1];
		end
	endfunction

	// predicts the response word for one request, updating the shadow table
	function automatic ffa_rsp_t predict_alloc_rsp(ffa_req_t r);
		ffa_rsp_t    p;
		logic [31:0] sz;
		logic [31:0] end_addr;
		int          i;
		bit          ok;
		p  = '0;
		sz = r.req_size;
		ok = 1'b0;
		if (sh_round)
			sz = (sz + PAGE_ADD) & PAGE_MASK;
		if (r.kind == KIND_ALLOC) begin
			for (i = 0; i < sh_used; i++) begin
				if (sh_len[i] >= sz) begin
					p.alloc_addr = sh_start[i];
					sh_start[i] = sh_start[i] + sz;
					sh_len[i]   = sh_len[i] - sz;
					if (sh_len[i] == 0)
						drop_entry(i);
					ok = 1'b1;
					break;
				end
			end
		end else begin
			end_addr = r.req_addr + sz;
			for (i = 0; i < sh_used; i++)
				if (sh_start[i] > r.req_addr)
					break;
			if (i > 0 && sh_start[i - 1] + sh_len[i - 1] == r.req_addr) begin
				sh_len[i - 1] = sh_len[i - 1] + sz;
				if (i < sh_used && end_addr == sh_start[i]) begin
					sh_len[i - 1] = sh_len[i - 1] + sh_len[i];
					drop_entry(i);
				end
				ok = 1'b1;
			end else if (i < sh_used && end_addr == sh_start[i]) begin
				sh_start[i] = r.req_addr;
				sh_len[i]   = sh_len[i] + sz;
				ok = 1'b1;
			end else if (sh_used < TABLE_DEPTH) begin
				for (int k = sh_used; k > i; k--) begin
					sh_start[k] = sh_start[k - 1];
					sh_len[k]   = sh_len[k - 1];
				end
				sh_used++;
				if (sh_peak < sh_used)
					sh_peak = sh_used;
				sh_start[i] = r.req_addr;
				sh_len[i]   = sz;
				ok = 1'b1;
			end else begin
				sh_lost_cnt   = sh_lost_cnt + 1;
				sh_lost_bytes = sh_lost_bytes + sz;
			end
		end
		p.success = ok;
		for (int k = 0; k < sh_used; k++)
			p.free_total = p.free_total + sh_len[k];
		p.region_count = sh_used[8:0];
		p.peak_regions = sh_peak[8:0];
		p.lost_frees   = sh_lost_cnt;
		p.lost_bytes   = sh_lost_bytes;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
		$display("MISMATCH %s: got %h want %h at cycle %0d", what, got, exp_v, cycle_count);
		error_count++;
	endtask

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// input driver: bursts of idle cycles between words
	int       drv_idle;
	ffa_req_t drv_req;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			drv_idle <= 0;
		end else if (in_valid && !in_ready) begin
			// hold the word
		end else if (drv_idle > 0) begin
			in_valid <= 1'b0;
			drv_idle <= drv_idle - 1;
		end else if (pending_reqs.size() > 0) begin
			drv_req = pending_reqs.pop_front();
			in_valid <= 1'b1;
			in_data  <= drv_req;
			expected_rsps.push_back(predict_alloc_rsp(drv_req));
			if (!quiet_tail && $urandom_range(0, 9) == 0)
				drv_idle <= $urandom_range(1, 12);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor and response-side stalls
	int mon_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			mon_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected word", 32'h0, 32'h0);
				end else begin
					ffa_rsp_t e;
					e = expected_rsps.pop_front();
					if (out_data.alloc_addr !== e.alloc_addr)
						report_mismatch("alloc_addr", out_data.alloc_addr, e.alloc_addr);
					if (out_data.success !== e.success)
						report_mismatch("success", 32'(out_data.success), 32'(e.success));
					if (out_data.free_total !== e.free_total)
						report_mismatch("free_total", out_data.free_total, e.free_total);
					if (out_data.region_count !== e.region_count)
						report_mismatch("region_count", 32'(out_data.region_count),
							32'(e.region_count));
					if (out_data.peak_regions !== e.peak_regions)
						report_mismatch("peak_regions", 32'(out_data.peak_regions),
							32'(e.peak_regions));
					if (out_data.lost_frees !== e.lost_frees)
						report_mismatch("lost_frees", out_data.lost_frees, e.lost_frees);
					if (out_data.lost_bytes !== e.lost_bytes)
						report_mismatch("lost_bytes", out_data.lost_bytes, e.lost_bytes);
				end
			end
			if (mon_stall > 0) begin
				out_ready <= 1'b0;
				mon_stall <= mon_stall - 1;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				mon_stall <= $urandom_range(0, 11);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// writes the page-rounding bit; only called while the block is idle
	task automatic write_round_mode(logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sh_round = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (4 * TABLE_DEPTH + 16) @(posedge clk);
	endtask

	function automatic ffa_req_t make_req(logic k, logic [31:0] a, logic [31:0] s);
		ffa_req_t r;
		r.kind = k;
		r.req_addr = a;
		r.req_size = s;
		return r;
	endfunction

	// random word: mostly aligned frees and allocs that merge and split
	function automatic ffa_req_t rand_req(bit page_sized);
		logic [31:0] a;
		logic [31:0] s;
		case ($urandom_range(0, 9)) inside
			0: begin
				a = $urandom();
				s = $urandom();
			end
			[1:3]: begin
				a = $urandom_range(0, 255) * 32'h100;
				s = $urandom_range(1, 4) * 32'h80;
			end
			default: begin
				a = $urandom_range(0, 63) * 32'h1000;
				s = page_sized ? $urandom_range(0, 3) * 32'h1000 + $urandom_range(0, 32'hfff)
					: $urandom_range(0, 2) * 32'h1000 + $urandom_range(0, 32'h100);
			end
		endcase
		return make_req(1'($urandom_range(0, 1)), a, s);
	endfunction

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		quiet_tail  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, zero sizes, merges, wrap, extremes
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'hffffffff, 32'h0));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h1000, 32'h0));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'h0));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h1000, 32'h100));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h1200, 32'h100));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h1100, 32'h100));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h0f00, 32'h100));
		pending_reqs.push_back(make_req(KIND_FREE, 32'hffffff00, 32'h100));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h0, 32'hffffffff));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'hffffffff));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'h80));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'h400));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'h1));
		wait_drained();

		write_round_mode(1'b1);
		pending_reqs.push_back(make_req(KIND_FREE, 32'h8000, 32'h1));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h20000, 32'hfffff001));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'hfffff000));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'h1001));
		pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'hffffffff));
		wait_drained();

		// fill the table with isolated regions, then overflow it
		write_round_mode(1'b0);
		for (int n = 0; n < TABLE_DEPTH + 8; n++)
			pending_reqs.push_back(make_req(KIND_FREE, 32'h1000_0000 + n * 32'h40, 32'h10));
		pending_reqs.push_back(make_req(KIND_FREE, 32'h1000_0010, 32'h30));
		pending_reqs.push_back(make_req(KIND_FREE, 32'hf000_0000, 32'habcd));
		for (int n = 0; n < 40; n++)
			pending_reqs.push_back(make_req(KIND_ALLOC, 32'h0, 32'h10));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_round_mode(ph[0]);
			if (ph == 3)
				quiet_tail = 1'b1;
			for (int n = 0; n < 220; n++)
				pending_reqs.push_back(rand_req(ph[0]));
			wait_drained();
		end

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
